FILE: src/brc_pkg.sv
// Shared types and constants for the byte rotor cipher.
// No dependencies; every other file imports this package.
package brc_pkg;

  localparam int NUM_ROTORS_DEF = 3;
  localparam int NUM_START_REGS = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int SYM_W          = 8;
  localparam int SEL_W          = 2;

  localparam logic [SYM_W-1:0] NOTCH_OFFSET = 8'd67;

  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FINAL
  } state_t;

endpackage

FILE: src/brc_if.sv
// Valid/ready channel interfaces for the byte rotor cipher.
// Depends on brc_pkg for field widths.
interface brc_in_if import brc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [SEL_W-1:0] rotor_select;
  sym_t             table_index;
  sym_t             data_byte;

  modport source (output valid, cmd, rotor_select, table_index, data_byte, input ready);
  modport sink   (input valid, cmd, rotor_select, table_index, data_byte, output ready);
endinterface

interface brc_out_if import brc_pkg::*; ();
  logic valid;
  logic ready;
  sym_t out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

FILE: src/brc_ram.sv
// Wiring table memory: one write port, one read port with registered data.
// Depends on brc_pkg.
module brc_ram import brc_pkg::*; #(
  parameter int DEPTH = NUM_ROTORS_DEF * 256,
  parameter int AW    = $clog2(NUM_ROTORS_DEF * 256)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sym_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output sym_t          rdata
);

  sym_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/brc_core.sv
// Sequencer, shared offset add/subtract unit, rotor positions and start registers.
// Drives the two wiring memories. Depends on brc_pkg and brc_if.
module brc_core import brc_pkg::*; #(
  parameter int NUM_ROTORS = NUM_ROTORS_DEF,
  parameter int AW         = $clog2(NUM_ROTORS_DEF * 256)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  brc_in_if.sink               in_ch,
  brc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  sym_t                 cfg_wdata,
  output logic                 fwd_we,
  output logic [AW-1:0]        fwd_waddr,
  output sym_t                 fwd_wdata,
  output logic                 inv_we,
  output logic [AW-1:0]        inv_waddr,
  output sym_t                 inv_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  sym_t                 fwd_rdata,
  input  sym_t                 inv_rdata
);

  localparam int RIDX_W = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;
  localparam int STEP_W = $clog2(2 * NUM_ROTORS);
  localparam logic [STEP_W-1:0] FWD_LAST  = STEP_W'(NUM_ROTORS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * NUM_ROTORS - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  sym_t              s_r, s_nxt;
  sym_t              p_issue_r, p_issue_nxt;
  logic              refl_r, refl_nxt;
  logic              from_inv_r, from_inv_nxt;
  logic              out_valid_r, out_valid_nxt;
  sym_t              out_byte_r, out_byte_nxt;
  sym_t              pos_r [NUM_ROTORS];
  sym_t              pos_nxt [NUM_ROTORS];
  sym_t              start_r [NUM_START_REGS];
  sym_t              start_nxt [NUM_START_REGS];

  sym_t              start_ext [NUM_ROTORS];
  sym_t              pos_adv [NUM_ROTORS];
  logic              carry;
  logic [STEP_W-1:0] rot_step;
  logic [RIDX_W-1:0] rot_idx;
  sym_t              rdata_sel;
  sym_t              diff;
  sym_t              cur;
  sym_t              addr_byte;
  logic              in_acc;
  logic              fin_go;
  logic              sel_ok;

  // Shared unit: undo previous offset, reflect at the turn, apply next offset.
  always_comb begin
    rot_step  = (step_r <= FWD_LAST) ? step_r : (LAST_STEP - step_r);
    rot_idx   = RIDX_W'(rot_step);
    rdata_sel = from_inv_r ? inv_rdata : fwd_rdata;
    diff      = rdata_sel - p_issue_r;
    if (state_r == ST_LOOK && step_r == '0) begin
      cur = s_r;
    end else begin
      cur = refl_r ? ~diff : diff;
    end
    addr_byte = cur + pos_r[rot_idx];
    mem_raddr = (AW'(rot_idx) << 8) | AW'(addr_byte);
    mem_re    = (state_r == ST_LOOK);
  end

  // Odometer stepping and restart values.
  always_comb begin
    for (int r = 0; r < NUM_ROTORS; r++) begin
      start_ext[r] = (r < NUM_START_REGS) ? start_r[r % NUM_START_REGS] : '0;
    end
    carry = 1'b1;
    for (int r = 0; r < NUM_ROTORS; r++) begin
      pos_adv[r] = pos_r[r] + sym_t'(carry);
      carry      = (pos_adv[r] == (start_ext[r] + NOTCH_OFFSET));
    end
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign fin_go          = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign sel_ok          = int'(in_ch.rotor_select) < NUM_ROTORS;

  always_comb begin
    fwd_we    = 1'b0;
    inv_we    = 1'b0;
    fwd_waddr = (AW'(RIDX_W'(in_ch.rotor_select)) << 8) | AW'(in_ch.table_index);
    inv_waddr = (AW'(RIDX_W'(in_ch.rotor_select)) << 8) | AW'(in_ch.data_byte);
    fwd_wdata = in_ch.data_byte;
    inv_wdata = in_ch.table_index;

    state_nxt     = state_r;
    step_nxt      = step_r;
    s_nxt         = s_r;
    p_issue_nxt   = p_issue_r;
    refl_nxt      = refl_r;
    from_inv_nxt  = from_inv_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pos_nxt       = pos_r;
    start_nxt     = start_r;

    if (cfg_we && int'(cfg_index) < NUM_START_REGS) begin
      start_nxt[cfg_index] = cfg_wdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.cmd)
            CMD_DATA: begin
              s_nxt     = in_ch.data_byte;
              step_nxt  = '0;
              state_nxt = ST_LOOK;
            end
            CMD_LOAD: begin
              fwd_we = sel_ok;
              inv_we = sel_ok;
            end
            CMD_RESTART: begin
              pos_nxt = start_ext;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOK: begin
        p_issue_nxt  = pos_r[rot_idx];
        refl_nxt     = (step_r == FWD_LAST);
        from_inv_nxt = (step_r > FWD_LAST);
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (fin_go) begin
          out_byte_nxt  = cur;
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_adv;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < NUM_ROTORS; r++) begin
        pos_r[r] <= '0;
      end
      for (int r = 0; r < NUM_START_REGS; r++) begin
        start_r[r] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    p_issue_r  <= p_issue_nxt;
    refl_r     <= refl_nxt;
    from_inv_r <= from_inv_nxt;
    out_byte_r <= out_byte_nxt;
  end

  a_final_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINAL |-> ($past(state_r) == ST_LOOK || $past(state_r) == ST_FINAL))
    else $error("final state entered without lookup pass");

  a_data_starts_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == CMD_DATA) |=> (state_r == ST_LOOK && step_r == '0))
    else $error("data transaction did not start lookup at step zero");

  a_rotor0_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL && fin_go) |=> (pos_r[0] == $past(pos_r[0]) + 8'd1))
    else $error("rotor 0 did not advance by one after a result");

  a_pos_hold_look: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOK |=> $stable(pos_r[NUM_ROTORS-1]))
    else $error("rotor position changed during lookup pass");

endmodule

FILE: src/byte_rotor_cipher.sv
// Byte rotor cipher top level: core sequencer plus forward and inverse wiring memories.
// Depends on brc_pkg, brc_if, brc_ram and brc_core.
// Data transaction: one dependent wiring read per cycle through the shared offset unit,
// forward through each rotor, then back through the inverse tables; the result is
// registered, and the next transaction is accepted once the sequencer returns to idle.
// Load and restart transactions complete in idle. Synchronous active-low reset clears
// rotor positions and start registers; wiring memories are not cleared.
module byte_rotor_cipher import brc_pkg::*; #(
  parameter int NUM_ROTORS = NUM_ROTORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  brc_in_if.sink               in_ch,
  brc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  sym_t                 cfg_wdata
);

  localparam int DEPTH = NUM_ROTORS * 256;
  localparam int AW    = $clog2(NUM_ROTORS * 256);

  logic          fwd_we;
  logic [AW-1:0] fwd_waddr;
  sym_t          fwd_wdata;
  logic          inv_we;
  logic [AW-1:0] inv_waddr;
  sym_t          inv_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  sym_t          fwd_rdata;
  sym_t          inv_rdata;

  brc_core #(
    .NUM_ROTORS (NUM_ROTORS),
    .AW         (AW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fwd_we    (fwd_we),
    .fwd_waddr (fwd_waddr),
    .fwd_wdata (fwd_wdata),
    .inv_we    (inv_we),
    .inv_waddr (inv_waddr),
    .inv_wdata (inv_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .fwd_rdata (fwd_rdata),
    .inv_rdata (inv_rdata)
  );

  brc_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (fwd_rdata)
  );

  brc_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (inv_waddr),
    .wdata (inv_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (inv_rdata)
  );

endmodule
